[sv/rctr_pkg.sv]
// ----------------------------------------------------------------------------
// rctr_pkg
// Shared codes and controller/datapath interface types of the root counter
// timer block.
// ----------------------------------------------------------------------------
package rctr_pkg;

  // item kinds
  localparam logic [2:0] KIND_READ   = 3'd0;
  localparam logic [2:0] KIND_WRITE  = 3'd1;
  localparam logic [2:0] KIND_SYSCLK = 3'd2;
  localparam logic [2:0] KIND_DOTCLK = 3'd3;
  localparam logic [2:0] KIND_HBLANK = 3'd4;
  localparam logic [2:0] KIND_GATE   = 3'd5;

  // register codes inside one timer
  localparam logic [1:0] REG_COUNT  = 2'd0;
  localparam logic [1:0] REG_MODE   = 2'd1;
  localparam logic [1:0] REG_TARGET = 2'd2;
  localparam logic [1:0] REG_NONE   = 2'd3;

  localparam logic [1:0] TIMER_LAST = 2'd2;
  localparam logic [1:0] TIMER_NONE = 2'd3;

  localparam logic [15:0] MODE_WR_BITS = 16'h73FF;
  localparam logic [16:0] CNT_WRAP     = 17'h0FFFF;

  // sync modes
  localparam logic [1:0] SYNC_PAUSE_ON_GATE = 2'd0;
  localparam logic [1:0] SYNC_RESET_ON_GATE = 2'd1;
  localparam logic [1:0] SYNC_RESET_PAUSE   = 2'd2;
  localparam logic [1:0] SYNC_FREE_ON_GATE  = 2'd3;

  typedef struct packed {
    logic       latch;
    logic       exec;
    logic       start_div;
    logic       fin;
    logic       publish;
    logic [1:0] tix;
  } rctr_cmd_t;

  typedef struct packed {
    logic chk_req;
    logic need_div;
    logic multi;
    logic div_done;
  } rctr_sts_t;

endpackage

[sv/rctr_div.sv]
// ----------------------------------------------------------------------------
// rctr_div
// Restoring remainder unit: one dividend bit per cycle over the 17-bit dividend.
// ----------------------------------------------------------------------------
module rctr_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [16:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic [15:0] rem_o
);

  localparam int unsigned Steps = 17;
  localparam int unsigned CntW  = $clog2(Steps + 1);

  logic [16:0]     dvd_q, rem_q, shifted;
  logic [15:0]     div_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;

  assign shifted = {rem_q[15:0], dvd_q[16]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(Steps);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[15:0], 1'b0};
      rem_q <= (shifted >= {1'b0, div_q}) ? shifted - {1'b0, div_q} : shifted;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[15:0];

endmodule

[sv/rctr_datapath.sv]
// ----------------------------------------------------------------------------
// rctr_datapath
// Timer state, item decode, tick feed, hit and wrap logic, interrupt logic
// and the result register.
// ----------------------------------------------------------------------------
module rctr_datapath import rctr_pkg::*; #(
  parameter int unsigned RESET_PAUSE    = 2,
  parameter int unsigned WRITE_PAUSE    = 2,
  parameter int unsigned OVERFLOW_PAUSE = 2,
  parameter int unsigned MAX_TICKS      = 1023
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [2:0]  mode_i,
  input  logic [5:0]  register_offset_i,
  input  logic [15:0] write_data_i,
  input  logic [9:0]  tick_count_i,
  input  logic [1:0]  gate_timer_i,
  input  logic        gate_level_i,
  input  rctr_cmd_t   cmd_i,
  output rctr_sts_t   sts_o,
  output logic [15:0] read_data_o,
  output logic        bad_access_o,
  output logic [2:0]  irq_mask_o
);

  function automatic logic counting(input logic [15:0] m, input logic is_t2,
                                    input logic gate);
    logic r;
    if (!m[0]) r = 1'b1;
    else if (is_t2) r = (m[2:1] == SYNC_RESET_ON_GATE) || (m[2:1] == SYNC_RESET_PAUSE);
    else if (m[2:1] == SYNC_PAUSE_ON_GATE) r = !gate;
    else if (m[2:1] == SYNC_RESET_ON_GATE) r = 1'b1;
    else r = gate;
    return r;
  endfunction

  // item
  logic [2:0]  kind_q;
  logic [5:0]  off_q;
  logic [15:0] data_q;
  logic [9:0]  ticks_q;
  logic [1:0]  gt_q;
  logic        gl_q;

  // timer state
  logic [15:0] count_q  [3];
  logic [15:0] target_q [3];
  logic [15:0] mode_q   [3];
  logic [7:0]  pause_q  [3];
  logic [2:0]  gate_q, ext_q, on_q, shot_q;
  logic [2:0]  carry_q;

  // work and result
  logic [15:0] old_q;
  logic [16:0] cur_q;
  logic [15:0] rd_q, out_rd_q;
  logic        bad_q, out_bad_q;
  logic [2:0]  irq_q, out_irq_q;

  logic [1:0]  tmr, rg, tsel, idx;
  logic        acc_bad, tvalid;
  logic [15:0] cnt, tgt, md;
  logic [7:0]  pse, pse_after;
  logic [10:0] total;
  logic        feed_en, feed_go, p_ge, carry_upd;
  logic [9:0]  amt, amt_left;
  logic        chk_req;
  logic        hit, need_div, ovf, req, fire_ok, irq_new;
  logic [16:0] c1, c2;
  logic [15:0] m1, m2, nm, mg;
  logic [15:0] div_rem;
  logic        div_done;
  logic [9:0]  ticks_sat;

  assign ticks_sat = ({7'd0, tick_count_i} > 17'(MAX_TICKS)) ? 10'(MAX_TICKS)
                                                             : tick_count_i;

  assign tmr     = off_q[5:4];
  assign rg      = off_q[3:2];
  assign acc_bad = (tmr == TIMER_NONE) || (rg == REG_NONE);

  always_comb begin
    case (kind_q)
      KIND_SYSCLK: tsel = cmd_i.tix;
      KIND_DOTCLK: tsel = 2'd0;
      KIND_HBLANK: tsel = 2'd1;
      KIND_GATE:   tsel = gt_q;
      default:     tsel = tmr;
    endcase
  end

  assign tvalid = (tsel != TIMER_NONE);
  assign idx    = tvalid ? tsel : 2'd0;
  assign cnt    = count_q[idx];
  assign tgt    = target_q[idx];
  assign md     = mode_q[idx];
  assign pse    = pause_q[idx];

  // tick feed
  assign total = {1'b0, ticks_q} + 11'(carry_q);

  always_comb begin
    feed_en   = 1'b0;
    carry_upd = 1'b0;
    amt       = ticks_q;
    case (kind_q)
      KIND_SYSCLK: begin
        if (idx == TIMER_LAST && ext_q[idx]) begin
          carry_upd = on_q[idx];
          feed_en   = on_q[idx] && (total[10:3] != 8'd0);
          amt       = 10'(total[10:3]);
        end else begin
          feed_en = on_q[idx] && !ext_q[idx];
        end
      end
      KIND_DOTCLK, KIND_HBLANK: feed_en = ext_q[idx] && on_q[idx];
      default: feed_en = 1'b0;
    endcase
  end

  assign p_ge      = ({2'd0, pse} <= amt);
  assign amt_left  = amt - {2'd0, pse};
  assign feed_go   = feed_en && ((pse == 8'd0) || p_ge) && on_q[idx];
  assign pse_after = ((pse == 8'd0) || p_ge) ? 8'd0 : pse - amt[7:0];

  always_comb begin
    chk_req = 1'b0;
    case (kind_q)
      KIND_WRITE: chk_req = !acc_bad && ((rg == REG_COUNT) ||
                            (rg == REG_TARGET && cnt >= data_q && md[4]));
      KIND_SYSCLK, KIND_DOTCLK, KIND_HBLANK: chk_req = feed_go;
      default: chk_req = 1'b0;
    endcase
  end

  // target and overflow hits
  assign hit      = (cur_q >= {1'b0, tgt}) && ((old_q < tgt) || (tgt == 16'd0));
  assign need_div = hit && md[3] && (tgt != 16'd0);
  assign c1       = need_div ? {1'b0, div_rem} : cur_q;
  assign ovf      = (c1 >= CNT_WRAP);
  assign c2       = ovf ? c1 - CNT_WRAP : c1;
  assign m1       = md | {3'd0, ovf, hit, 11'd0};
  assign req      = (hit && md[4]) || (ovf && md[5]);
  assign fire_ok  = md[6] || !shot_q[idx];

  always_comb begin
    m2      = m1;
    irq_new = 1'b0;
    if (req && fire_ok) begin
      if (!md[7]) begin
        m2      = m1 | 16'h0400;
        irq_new = 1'b1;
      end else begin
        m2      = m1 ^ 16'h0400;
        irq_new = !m2[10];
      end
    end
  end

  // mode write value: irq request set, sticky flags cleared
  assign nm = (((data_q & MODE_WR_BITS) | (md & ~MODE_WR_BITS)) | 16'h0400) & ~16'h1800;
  // gate: free-on-gate turns sync off at the active edge
  assign mg = (gl_q && md[2:1] == SYNC_FREE_ON_GATE) ? (md & ~16'h0001) : md;

  rctr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start_div),
    .dividend_i (cur_q),
    .divisor_i  (tgt),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        count_q[i]  <= '0;
        target_q[i] <= '0;
        mode_q[i]   <= 16'h0400;
        pause_q[i]  <= '0;
      end
      gate_q  <= '0;
      ext_q   <= '0;
      on_q    <= '1;
      shot_q  <= '0;
      carry_q <= '0;
    end else begin
      if (cmd_i.exec) begin
        case (kind_q)
          KIND_READ: begin
            if (!acc_bad && rg == REG_MODE) mode_q[idx] <= md & ~16'h1800;
          end
          KIND_WRITE: begin
            if (!acc_bad) begin
              case (rg)
                REG_COUNT: pause_q[idx] <= 8'(WRITE_PAUSE);
                REG_MODE: begin
                  mode_q[idx]  <= nm;
                  count_q[idx] <= '0;
                  pause_q[idx] <= 8'(RESET_PAUSE);
                  ext_q[idx]   <= (idx == TIMER_LAST) ? nm[9] : nm[8];
                  shot_q[idx]  <= 1'b0;
                  on_q[idx]    <= counting(nm, idx == TIMER_LAST, gate_q[idx]);
                end
                REG_TARGET: target_q[idx] <= data_q;
                default: ;
              endcase
            end
          end
          KIND_SYSCLK, KIND_DOTCLK, KIND_HBLANK: begin
            if (feed_en) pause_q[idx] <= pse_after;
            if (carry_upd) carry_q <= total[2:0];
          end
          KIND_GATE: begin
            if (tvalid && gate_q[idx] != gl_q) begin
              gate_q[idx] <= gl_q;
              if (md[0]) begin
                if (md[2:1] == SYNC_RESET_ON_GATE) begin
                  if (!gl_q) begin
                    count_q[idx] <= '0;
                    pause_q[idx] <= 8'(RESET_PAUSE);
                  end
                end else begin
                  if (gl_q && md[2:1] == SYNC_RESET_PAUSE) begin
                    count_q[idx] <= '0;
                    pause_q[idx] <= 8'(RESET_PAUSE);
                  end
                  mode_q[idx] <= mg;
                  on_q[idx]   <= counting(mg, idx == TIMER_LAST, gl_q);
                end
              end
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.fin) begin
        count_q[idx] <= c2[15:0];
        mode_q[idx]  <= m2;
        if (ovf) pause_q[idx] <= 8'(OVERFLOW_PAUSE);
        else if (need_div) pause_q[idx] <= 8'(RESET_PAUSE);
        if (req && fire_ok) shot_q[idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q  <= mode_i;
      off_q   <= register_offset_i;
      data_q  <= write_data_i;
      ticks_q <= ticks_sat;
      gt_q    <= gate_timer_i;
      gl_q    <= gate_level_i;
      rd_q    <= '0;
      bad_q   <= 1'b0;
      irq_q   <= '0;
    end
    if (cmd_i.exec) begin
      if (kind_q == KIND_READ || kind_q == KIND_WRITE) bad_q <= acc_bad;
      if (kind_q == KIND_READ) begin
        if (acc_bad) rd_q <= 16'hFFFF;
        else if (rg == REG_COUNT) rd_q <= cnt;
        else if (rg == REG_MODE) rd_q <= md;
        else rd_q <= tgt;
      end
      old_q <= cnt;
      if (kind_q == KIND_WRITE && rg == REG_COUNT) cur_q <= {1'b0, data_q};
      else if (kind_q == KIND_WRITE) cur_q <= {1'b0, cnt};
      else cur_q <= {1'b0, cnt} + 17'(amt_left);
    end
    if (cmd_i.fin && irq_new) irq_q <= irq_q | (3'b001 << idx);
    if (cmd_i.publish) begin
      out_rd_q  <= rd_q;
      out_bad_q <= bad_q;
      out_irq_q <= irq_q;
    end
  end

  assign sts_o.chk_req  = chk_req;
  assign sts_o.need_div = need_div;
  assign sts_o.multi    = (kind_q == KIND_SYSCLK);
  assign sts_o.div_done = div_done;

  assign read_data_o  = out_rd_q;
  assign bad_access_o = out_bad_q;
  assign irq_mask_o   = out_irq_q;

endmodule

[sv/rctr_ctrl.sv]
// ----------------------------------------------------------------------------
// rctr_ctrl
// Sequencer: accepts an item, walks the affected timers through feed, hit
// check, optional wrap division and update, then hands the result out.
// ----------------------------------------------------------------------------
module rctr_ctrl import rctr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  rctr_sts_t sts_i,
  output rctr_cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EXEC = 7'b0000010,
    S_CHK  = 7'b0000100,
    S_DIV  = 7'b0001000,
    S_FIN  = 7'b0010000,
    S_NEXT = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] tix_q, tix_d;
  logic       out_valid_q, out_valid_d;
  logic       publish;

  assign in_ready_o = (state_q == S_IDLE);
  assign publish    = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    tix_d   = tix_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
          tix_d   = '0;
        end
      end
      S_EXEC:  state_d = sts_i.chk_req ? S_CHK : S_NEXT;
      S_CHK:   state_d = sts_i.need_div ? S_DIV : S_FIN;
      S_DIV:   if (sts_i.div_done) state_d = S_FIN;
      S_FIN:   state_d = S_NEXT;
      S_NEXT: begin
        if (sts_i.multi && tix_q != TIMER_LAST) begin
          tix_d   = tix_q + 2'd1;
          state_d = S_EXEC;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE:  if (publish) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (publish) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tix_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tix_q       <= tix_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o.latch     = in_ready_o && in_valid_i;
  assign cmd_o.exec      = (state_q == S_EXEC);
  assign cmd_o.start_div = (state_q == S_CHK) && sts_i.need_div;
  assign cmd_o.fin       = (state_q == S_FIN);
  assign cmd_o.publish   = publish;
  assign cmd_o.tix       = tix_q;

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_publish_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |-> (!out_valid_q || out_ready_i))
    else $error("result published over a waiting one");
  a_div_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start_div |=> (state_q == S_DIV))
    else $error("division start without wait state");
  a_latch_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.latch |=> (state_q == S_EXEC && tix_q == 2'd0))
    else $error("accepted item not dispatched");
  a_tix_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tix_q != TIMER_NONE))
    else $error("timer index out of range");
`endif

endmodule

[sv/three_channel_root_counter_timer.sv]
// ----------------------------------------------------------------------------
// three_channel_root_counter_timer
// Three 16-bit root counters with target, sticky flags, sync modes and irqs.
// ----------------------------------------------------------------------------
// Usage: one input channel (in_valid_i/in_ready_o) carries items: bus read,
// bus write, batch of sysclk, dotclock or hblank ticks, or a gate change.
// Every item yields exactly one result transfer on out_valid_o/out_ready_i:
// read data, a bad access flag and the irq bits raised by that item.
// Each item passes through the exec, next and done states; each timer whose
// counter is checked adds a check and an update state, and a target wrap adds
// a wait state for the bit-serial remainder unit. A sysclk batch walks all
// three timers in turn.
// One item is in flight at a time; a new item is taken as soon as the
// sequencer is idle, even while the previous result still waits in the
// output register. If the receiver stalls, the finished item waits until
// the output register frees up, and input stays blocked meanwhile.
// Reset: counters and targets zero, mode words 0x0400, all timers counting,
// no pause pending, no result valid.
// ----------------------------------------------------------------------------
module three_channel_root_counter_timer import rctr_pkg::*; #(
  parameter int unsigned RESET_PAUSE    = 2,
  parameter int unsigned WRITE_PAUSE    = 2,
  parameter int unsigned OVERFLOW_PAUSE = 2,
  parameter int unsigned MAX_TICKS      = 1023
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  mode_i,
  input  logic [5:0]  register_offset_i,
  input  logic [15:0] write_data_i,
  input  logic [9:0]  tick_count_i,
  input  logic [1:0]  gate_timer_i,
  input  logic        gate_level_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] read_data_o,
  output logic        bad_access_o,
  output logic [2:0]  irq_mask_o
);

  rctr_cmd_t cmd;
  rctr_sts_t sts;

  rctr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rctr_datapath #(
    .RESET_PAUSE    (RESET_PAUSE),
    .WRITE_PAUSE    (WRITE_PAUSE),
    .OVERFLOW_PAUSE (OVERFLOW_PAUSE),
    .MAX_TICKS      (MAX_TICKS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .mode_i            (mode_i),
    .register_offset_i (register_offset_i),
    .write_data_i      (write_data_i),
    .tick_count_i      (tick_count_i),
    .gate_timer_i      (gate_timer_i),
    .gate_level_i      (gate_level_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .read_data_o       (read_data_o),
    .bad_access_o      (bad_access_o),
    .irq_mask_o        (irq_mask_o)
  );

endmodule

[sim/tb_three_channel_root_counter_timer.sv]
// ----------------------------------------------------------------------------
// tb_three_channel_root_counter_timer
// Self-checking bench for the three-channel root counter timer. A short
// directed table runs first: reset values, bad accesses, spare kinds, target
// wraps, overflow, the divided clock of timer 2 and a gate mode. Random bus
// traffic and tick batches follow, under several input and output idling
// phases. Results are checked against typed rows or a timer state predictor.
// ----------------------------------------------------------------------------
module tb_three_channel_root_counter_timer import rctr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RST_HOLD  = 2;
  localparam int unsigned WR_HOLD   = 2;
  localparam int unsigned OVF_HOLD  = 2;
  localparam int unsigned TICK_SAT  = 1023;
  localparam logic [2:0]  KIND_SPARE_A = 3'd6;
  localparam logic [2:0]  KIND_SPARE_B = 3'd7;
  localparam int unsigned RANDOM_ITEMS = 900;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  offset;
    logic [15:0] data;
    logic [9:0]  ticks;
    logic [1:0]  gtimer;
    logic        glevel;
  } tmr_item_t;

  typedef struct packed {
    logic [15:0] rd;
    logic        bad;
    logic [2:0]  irq;
  } tmr_result_t;

  typedef struct packed {
    tmr_item_t   item;
    logic        typed;
    tmr_result_t res;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  mode_i = '0;
  logic [5:0]  register_offset_i = '0;
  logic [15:0] write_data_i = '0;
  logic [9:0]  tick_count_i = '0;
  logic [1:0]  gate_timer_i = '0;
  logic        gate_level_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] read_data_o;
  logic        bad_access_o;
  logic [2:0]  irq_mask_o;

  three_channel_root_counter_timer dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // timer state as the predictor sees it
  logic [15:0] cnt_q [3];
  logic [15:0] tgt_q [3];
  logic [15:0] mw_q [3];
  logic        gate_q [3];
  logic        ext_q [3];
  logic        run_q [3];
  logic        fired_q [3];
  int unsigned hold_q [3];
  logic [2:0]  carry_q;
  logic [2:0]  irq_q;

  tmr_result_t expected_results[$];
  int unsigned errors = 0;
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;

  task automatic report(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0h want %0h (t=%0t)", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void refresh_run(int t);
    logic [1:0] sm;
    sm = mw_q[t][2:1];
    if (!mw_q[t][0]) run_q[t] = 1'b1;
    else if (t == 2) run_q[t] = (sm == SYNC_RESET_ON_GATE || sm == SYNC_RESET_PAUSE);
    else if (sm == SYNC_PAUSE_ON_GATE) run_q[t] = !gate_q[t];
    else if (sm == SYNC_RESET_ON_GATE) run_q[t] = 1'b1;
    else run_q[t] = gate_q[t];
  endfunction

  function automatic void raise_irq(int t);
    if (!mw_q[t][6] && fired_q[t]) return;
    if (!mw_q[t][7]) begin
      mw_q[t][10] = 1'b1;
      irq_q[t] = 1'b1;
    end else begin
      mw_q[t][10] = !mw_q[t][10];
      if (!mw_q[t][10]) irq_q[t] = 1'b1;
    end
    fired_q[t] = 1'b1;
  endfunction

  function automatic void check_hits(int t, int unsigned old, int unsigned cur);
    logic        req;
    int unsigned tg;
    req = 1'b0;
    tg = tgt_q[t];
    if (cur >= tg && (old < tg || tg == 0)) begin
      mw_q[t][11] = 1'b1;
      if (mw_q[t][4]) req = 1'b1;
      if (mw_q[t][3] && tg > 0) begin
        cur = cur % tg;
        hold_q[t] = RST_HOLD;
      end
    end
    if (cur >= 32'hFFFF) begin
      mw_q[t][12] = 1'b1;
      if (mw_q[t][5]) req = 1'b1;
      cur = cur % 32'hFFFF;
      hold_q[t] = OVF_HOLD;
    end
    cnt_q[t] = cur[15:0];
    if (req) raise_irq(t);
  endfunction

  function automatic void feed_ticks(int t, int unsigned n);
    if (hold_q[t] > 0) begin
      if (n >= hold_q[t]) begin
        n -= hold_q[t];
        hold_q[t] = 0;
      end else begin
        hold_q[t] -= n;
        return;
      end
    end
    if (!run_q[t]) return;
    check_hits(t, cnt_q[t], cnt_q[t] + n);
  endfunction

  function automatic void reset_timers();
    for (int t = 0; t < 3; t++) begin
      cnt_q[t] = '0;
      tgt_q[t] = '0;
      mw_q[t] = 16'h0400;
      gate_q[t] = 1'b0;
      ext_q[t] = 1'b0;
      run_q[t] = 1'b1;
      fired_q[t] = 1'b0;
      hold_q[t] = 0;
    end
    carry_q = '0;
  endfunction

  function automatic tmr_result_t predict_timers(tmr_item_t it);
    tmr_result_t r;
    int          t;
    logic [1:0]  rg;
    logic        bad;
    int unsigned n;
    int unsigned total;
    logic [1:0]  sm;
    int          g;
    t = it.offset[5:4];
    rg = it.offset[3:2];
    bad = (it.offset[5:4] == TIMER_NONE) || (rg == REG_NONE);
    r = '0;
    irq_q = '0;
    n = (it.ticks > TICK_SAT) ? TICK_SAT : it.ticks;
    case (it.kind)
      KIND_READ: begin
        if (bad) r.rd = 16'hFFFF;
        else if (rg == REG_COUNT) r.rd = cnt_q[t];
        else if (rg == REG_MODE) begin
          r.rd = mw_q[t];
          mw_q[t][12:11] = 2'b00;
        end else r.rd = tgt_q[t];
        r.bad = bad;
      end
      KIND_WRITE: begin
        r.bad = bad;
        if (!bad && rg == REG_COUNT) begin
          n = cnt_q[t];
          cnt_q[t] = it.data;
          hold_q[t] = WR_HOLD;
          check_hits(t, n, it.data);
        end else if (!bad && rg == REG_MODE) begin
          mw_q[t] = (it.data & MODE_WR_BITS) | (mw_q[t] & ~MODE_WR_BITS);
          cnt_q[t] = '0;
          hold_q[t] = RST_HOLD;
          ext_q[t] = (t == 2) ? mw_q[t][9] : mw_q[t][8];
          fired_q[t] = 1'b0;
          mw_q[t][10] = 1'b1;
          mw_q[t][12:11] = 2'b00;
          refresh_run(t);
        end else if (!bad) begin
          tgt_q[t] = it.data;
          if (cnt_q[t] >= tgt_q[t] && mw_q[t][4]) check_hits(t, cnt_q[t], cnt_q[t]);
        end
      end
      KIND_SYSCLK: begin
        if (run_q[0] && !ext_q[0]) feed_ticks(0, n);
        if (run_q[1] && !ext_q[1]) feed_ticks(1, n);
        if (run_q[2]) begin
          if (ext_q[2]) begin
            total = n + carry_q;
            carry_q = total[2:0];
            if ((total >> 3) > 0) feed_ticks(2, total >> 3);
          end else feed_ticks(2, n);
        end
      end
      KIND_DOTCLK, KIND_HBLANK: begin
        g = (it.kind == KIND_DOTCLK) ? 0 : 1;
        if (ext_q[g] && run_q[g]) feed_ticks(g, n);
      end
      KIND_GATE: begin
        g = it.gtimer;
        if (it.gtimer != TIMER_NONE && gate_q[g] != it.glevel) begin
          gate_q[g] = it.glevel;
          if (mw_q[g][0]) begin
            sm = mw_q[g][2:1];
            if (sm == SYNC_RESET_ON_GATE) begin
              if (!it.glevel) begin
                cnt_q[g] = '0;
                hold_q[g] = RST_HOLD;
              end
            end else begin
              if (it.glevel && sm == SYNC_RESET_PAUSE) begin
                cnt_q[g] = '0;
                hold_q[g] = RST_HOLD;
              end
              if (it.glevel && sm == SYNC_FREE_ON_GATE) mw_q[g][0] = 1'b0;
              refresh_run(g);
            end
          end
        end
      end
      default: ;
    endcase
    r.irq = irq_q;
    return r;
  endfunction

  function automatic tmr_item_t mk(logic [2:0] k, logic [5:0] o, logic [15:0] d,
                                   logic [9:0] n, logic [1:0] gt, logic gl);
    tmr_item_t it;
    it.kind = k;
    it.offset = o;
    it.data = d;
    it.ticks = n;
    it.gtimer = gt;
    it.glevel = gl;
    return it;
  endfunction

  function automatic logic [5:0] addr(int t, logic [1:0] rg);
    return {t[1:0], rg, 2'($urandom_range(3))};
  endfunction

  // mostly well-formed traffic on valid registers, with some noise
  function automatic tmr_item_t random_item();
    int unsigned sel;
    int          t;
    logic [15:0] d;
    logic [9:0]  n;
    sel = $urandom_range(99);
    t = $urandom_range(2);
    n = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 300));
    d = 16'($urandom);
    case ($urandom_range(3))
      0: d = 16'($urandom_range(0, 400));
      1: d = 16'($urandom_range(0, 2000));
      default: ;
    endcase
    if (sel < 12) return mk(KIND_WRITE, addr(t, REG_MODE), 16'($urandom), 10'd0, 2'd0, 1'b0);
    if (sel < 22) return mk(KIND_WRITE, addr(t, REG_TARGET), d, n, 2'd0, 1'b0);
    if (sel < 28) return mk(KIND_WRITE, addr(t, REG_COUNT), d, 10'd0, 2'd0, 1'b0);
    if (sel < 45) return mk(KIND_READ, addr(t, 2'($urandom_range(2))), d, n, 2'd0, 1'b0);
    if (sel < 68) return mk(KIND_SYSCLK, 6'($urandom), d, n, 2'd0, 1'b0);
    if (sel < 78) return mk($urandom_range(1) ? KIND_DOTCLK : KIND_HBLANK, 6'($urandom),
                            d, n, 2'd0, 1'b0);
    if (sel < 90) return mk(KIND_GATE, 6'($urandom), d, n, 2'($urandom), 1'($urandom));
    if (sel < 96) return mk($urandom_range(1) ? KIND_READ : KIND_WRITE, 6'($urandom),
                            16'($urandom), n, 2'd0, 1'b0);
    return mk($urandom_range(1) ? KIND_SPARE_A : KIND_SPARE_B, 6'($urandom),
              16'($urandom), n, 2'($urandom), 1'($urandom));
  endfunction

  task automatic send(tmr_item_t it, logic typed, tmr_result_t want);
    tmr_result_t r;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= it.kind;
    register_offset_i <= it.offset;
    write_data_i <= it.data;
    tick_count_i <= it.ticks;
    gate_timer_i <= it.gtimer;
    gate_level_i <= it.glevel;
    do @(posedge clk_i); while (!in_ready_o);
    r = predict_timers(it);
    expected_results.push_back(typed ? want : r);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= !($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    tmr_result_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report("unexpected result", read_data_o, 0);
      end else begin
        w = expected_results.pop_front();
        if (read_data_o !== w.rd) report("read_data", read_data_o, w.rd);
        if (bad_access_o !== w.bad) report("bad_access", bad_access_o, w.bad);
        if (irq_mask_o !== w.irq) report("irq_mask", irq_mask_o, w.irq);
      end
    end
  end

  dir_row_t dir_rows[] = '{
    '{mk(KIND_READ,   6'h00, 16'h0000, 10'd0,    2'd0, 1'b0), 1'b1, '{16'h0000, 1'b0, 3'd0}},
    '{mk(KIND_READ,   6'h04, 16'h0000, 10'd0,    2'd0, 1'b0), 1'b1, '{16'h0400, 1'b0, 3'd0}},
    '{mk(KIND_READ,   6'h30, 16'h0000, 10'd0,    2'd0, 1'b0), 1'b1, '{16'hFFFF, 1'b1, 3'd0}},
    '{mk(KIND_READ,   6'h1C, 16'h0000, 10'd0,    2'd0, 1'b0), 1'b1, '{16'hFFFF, 1'b1, 3'd0}},
    '{mk(KIND_WRITE,  6'h2F, 16'hFFFF, 10'd0,    2'd0, 1'b0), 1'b1, '{16'h0000, 1'b1, 3'd0}},
    '{mk(KIND_WRITE,  6'h3B, 16'hFFFF, 10'd0,    2'd0, 1'b0), 1'b1, '{16'h0000, 1'b1, 3'd0}},
    '{mk(KIND_SPARE_A, 6'h3F, 16'hFFFF, 10'h3FF, 2'd3, 1'b1), 1'b1, '{16'h0000, 1'b0, 3'd0}},
    '{mk(KIND_SPARE_B, 6'h00, 16'h0000, 10'd0,   2'd0, 1'b0), 1'b1, '{16'h0000, 1'b0, 3'd0}},
    '{mk(KIND_SYSCLK, 6'h00, 16'h0000, 10'd0,    2'd0, 1'b0), 1'b0, '0},
    '{mk(KIND_WRITE,  6'h04, 16'h0018, 10'd0,    2'd0, 1'b0), 1'b0, '0},
    '{mk(KIND_WRITE,  6'h08, 16'd100,  10'd0,    2'd0, 1'b0), 1'b0, '0},
    '{mk(KIND_SYSCLK, 6'h00, 16'h0000, 10'h3FF,  2'd0, 1'b0), 1'b0, '0},
    '{mk(KIND_WRITE,  6'h14, 16'h0170, 10'd0,    2'd0, 1'b0), 1'b0, '0},
    '{mk(KIND_WRITE,  6'h18, 16'h0000, 10'd0,    2'd0, 1'b0), 1'b0, '0},
    '{mk(KIND_HBLANK, 6'h00, 16'h0000, 10'd5,    2'd0, 1'b0), 1'b0, '0},
    '{mk(KIND_WRITE,  6'h24, 16'h02F0, 10'd0,    2'd0, 1'b0), 1'b0, '0},
    '{mk(KIND_WRITE,  6'h28, 16'd3,    10'd0,    2'd0, 1'b0), 1'b0, '0},
    '{mk(KIND_SYSCLK, 6'h00, 16'h0000, 10'h3FF,  2'd0, 1'b0), 1'b0, '0},
    '{mk(KIND_WRITE,  6'h04, 16'h0003, 10'd0,    2'd0, 1'b0), 1'b0, '0},
    '{mk(KIND_GATE,   6'h00, 16'h0000, 10'd0,    2'd0, 1'b1), 1'b0, '0},
    '{mk(KIND_GATE,   6'h00, 16'h0000, 10'd0,    2'd0, 1'b0), 1'b0, '0},
    '{mk(KIND_GATE,   6'h00, 16'h0000, 10'd0,    2'd3, 1'b1), 1'b0, '0},
    '{mk(KIND_WRITE,  6'h10, 16'hFFFF, 10'd0,    2'd0, 1'b0), 1'b0, '0},
    '{mk(KIND_WRITE,  6'h24, 16'h73FF, 10'd0,    2'd0, 1'b0), 1'b0, '0},
    '{mk(KIND_READ,   6'h24, 16'h0000, 10'd0,    2'd0, 1'b0), 1'b0, '0}
  };

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    reset_timers();
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (dir_rows[i]) send(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 63; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 63; end
        default: begin send_gap_pct = 36; stall_pct = 36; end
      endcase
      // hold off until the results of the previous phase have drained
      if (ph == 2) begin
        in_valid_i <= 1'b0;
        while (expected_results.size() != 0) @(negedge clk_i);
      end
      for (int i = 0; i < RANDOM_ITEMS / 4; i++) send(random_item(), 1'b0, '0);
    end
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
